// ===== sv/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// Widths and pipeline depths shared by the vector normalize block.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Component and result widths
  localparam int IN_W   = 32;
  localparam int FRAC   = 30;
  localparam int OUT_W  = FRAC + 2;

  // Square of a magnitude, and sum of three squares
  localparam int SQ_W   = 2 * IN_W;
  localparam int SUM_W  = SQ_W + 2;

  // Quotient a^2 * 4^(FRAC+1) / sum lies in [0, 2^(2*FRAC+2)]
  localparam int Q_W    = 2 * FRAC + 3;
  // Partial remainder of the divider, one bit above the divisor
  localparam int REM_W  = SUM_W + 1;

  // Integer square root of the quotient lies in [0, 2^(FRAC+1)]
  localparam int ROOT_W = FRAC + 2;
  localparam int SR_W   = Q_W + 1;
  localparam int TRY_W  = Q_W + 3;

  // Rounded magnitude before clamping, one bit above the root
  localparam int HALF_W = ROOT_W + 1;

  // Stages inside the magnitude pipe: one per quotient bit, one per root bit
  localparam int MAG_LAT = Q_W + ROOT_W;

endpackage

// ===== sv/vn_mag_pipe.sv =====
// ----------------------------------------------------------------------------
// vn_mag_pipe
// Pipelined exact divide then integer square root: root = isqrt(floor(a2 *
// 4^(FRAC+1)/sum)). One restoring step per stage, one word per enabled cycle.
// ----------------------------------------------------------------------------
module vn_mag_pipe (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vn_pkg::SQ_W-1:0]       a2,
  input  logic [vn_pkg::SUM_W-1:0]      sum,
  output logic [vn_pkg::ROOT_W-1:0]     root
);

  // Divider stage registers
  logic [vn_pkg::REM_W-1:0]  drem [vn_pkg::Q_W];
  logic [vn_pkg::Q_W-1:0]    dq   [vn_pkg::Q_W];
  logic [vn_pkg::SUM_W-1:0]  dsum [vn_pkg::Q_W];

  // Square root stage registers
  logic [vn_pkg::SR_W-1:0]   srem  [vn_pkg::ROOT_W];
  logic [vn_pkg::ROOT_W-1:0] sroot [vn_pkg::ROOT_W];

  genvar k;

  // Long division: the dividend is a2 followed by 2*FRAC+2 zero bits
  generate
    for (k = 0; k < vn_pkg::Q_W; k++) begin : g_div
      logic [vn_pkg::REM_W-1:0] prem;
      logic [vn_pkg::Q_W-1:0]   pq;
      logic [vn_pkg::SUM_W-1:0] psum;
      logic                     nbit;
      logic [vn_pkg::REM_W-1:0] shr;
      logic [vn_pkg::REM_W:0]   diff;

      if (k == 0) begin : g_first
        assign prem = vn_pkg::REM_W'(a2[vn_pkg::SQ_W-1:1]);
        assign pq   = '0;
        assign psum = sum;
        assign nbit = a2[0];
      end else begin : g_rest
        assign prem = drem[k-1];
        assign pq   = dq[k-1];
        assign psum = dsum[k-1];
        assign nbit = 1'b0;
      end

      // Remainder stays below the divisor, so the top bit drops out
      assign shr  = {prem[vn_pkg::REM_W-2:0], nbit};
      assign diff = {1'b0, shr} - {2'b00, psum};

      always_ff @(posedge clk) begin
        if (en) begin
          dsum[k] <= psum;
          if (!diff[vn_pkg::REM_W]) begin
            drem[k] <= diff[vn_pkg::REM_W-1:0];
            dq[k]   <= {pq[vn_pkg::Q_W-2:0], 1'b1};
          end else begin
            drem[k] <= shr;
            dq[k]   <= {pq[vn_pkg::Q_W-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // Bitwise square root, remainder kept as D - root^2
  generate
    for (k = 0; k < vn_pkg::ROOT_W; k++) begin : g_sqrt
      localparam int B = vn_pkg::ROOT_W - 1 - k;
      logic [vn_pkg::SR_W-1:0]   prem;
      logic [vn_pkg::ROOT_W-1:0] proot;
      logic [vn_pkg::TRY_W-1:0]  trial;
      logic [vn_pkg::TRY_W-1:0]  remx;

      if (k == 0) begin : g_first
        assign prem  = vn_pkg::SR_W'(dq[vn_pkg::Q_W-1]);
        assign proot = '0;
      end else begin : g_rest
        assign prem  = srem[k-1];
        assign proot = sroot[k-1];
      end

      // (2*root + 2^B) * 2^B
      assign trial = (vn_pkg::TRY_W'(proot) << (B + 1))
                   + (vn_pkg::TRY_W'(1) << (2 * B));
      assign remx  = vn_pkg::TRY_W'(prem);

      always_ff @(posedge clk) begin
        if (en) begin
          if (remx >= trial) begin
            srem[k]  <= vn_pkg::SR_W'(remx - trial);
            sroot[k] <= proot | (vn_pkg::ROOT_W'(1) << B);
          end else begin
            srem[k]  <= prem;
            sroot[k] <= proot;
          end
        end
      end
    end
  endgenerate

  assign root = sroot[vn_pkg::ROOT_W-1];

endmodule

// ===== sv/vector3_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_top
// Unit vector of a signed three-component integer vector, signed Q2.30.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: comp_x/comp_y/comp_z with in_valid; the block drives
//   in_stall. Output channel: unit_x/unit_y/unit_z/zero_vector with
//   out_valid; the receiver drives out_stall. A word moves when valid is
//   high and stall is low at a rising edge.
//   Each magnitude is |c| * 2^30 / sqrt(x^2+y^2+z^2), rounded to nearest
//   (ties away from zero), clamped to 2^30, sign restored.
//   An all-zero vector gives zero_vector = 1 and zero unit fields.
// Pipeline: abs, square, sum, 63 divider steps, 32 square root steps and
//   the output register lie between acceptance and out_valid. The divider
//   and root pipes take one bit per stage.
// Throughput: one vector per cycle while out_stall holds no waiting result.
// Reset: clears all valid bits; the pipe is empty after reset.
// Stall: while out_stall holds a waiting result, the whole pipe freezes and
//   in_stall goes high; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vector3_normalize_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [vn_pkg::IN_W-1:0] comp_x,
  input  logic signed [vn_pkg::IN_W-1:0] comp_y,
  input  logic signed [vn_pkg::IN_W-1:0] comp_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [vn_pkg::OUT_W-1:0] unit_x,
  output logic signed [vn_pkg::OUT_W-1:0] unit_y,
  output logic signed [vn_pkg::OUT_W-1:0] unit_z,
  output logic                           zero_vector
);

  localparam int LAT = vn_pkg::MAG_LAT;

  logic adv;

  // Abs stage
  logic                      va;
  logic [vn_pkg::IN_W-1:0]   mag_a [3];
  logic [2:0]                neg_a;
  logic                      zero_a;

  // Square stage
  logic                      vb;
  logic [vn_pkg::SQ_W-1:0]   sq_b [3];
  logic [2:0]                neg_b;
  logic                      zero_b;

  // Sum stage
  logic                      vc;
  logic [vn_pkg::SQ_W-1:0]   sq_c [3];
  logic [vn_pkg::SUM_W-1:0]  sum_c;
  logic [2:0]                neg_c;
  logic                      zero_c;

  // Side band alongside the magnitude pipes
  logic                      vd    [LAT];
  logic [2:0]                neg_d [LAT];
  logic                      zero_d[LAT];

  logic [vn_pkg::ROOT_W-1:0] root [3];
  logic [vn_pkg::OUT_W-1:0]  res  [3];

  logic signed [vn_pkg::IN_W-1:0] comp [3];

  // Whole pipe moves unless a finished word is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < LAT; i++) vd[i] <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd[0]     <= vc;
      for (int i = 1; i < LAT; i++) vd[i] <= vd[i-1];
      out_valid <= vd[LAT-1];
    end
  end

  // Front stages: magnitude, square, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= comp[i][vn_pkg::IN_W-1];
        mag_a[i] <= comp[i][vn_pkg::IN_W-1] ? (~comp[i] + 1'b1) : comp[i];
        sq_b[i]  <= vn_pkg::SQ_W'(mag_a[i]) * vn_pkg::SQ_W'(mag_a[i]);
        sq_c[i]  <= sq_b[i];
      end
      zero_a <= (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
      neg_b  <= neg_a;
      zero_b <= zero_a;
      sum_c  <= vn_pkg::SUM_W'(sq_b[0]) + vn_pkg::SUM_W'(sq_b[1])
              + vn_pkg::SUM_W'(sq_b[2]);
      neg_c  <= neg_b;
      zero_c <= zero_b;
    end
  end

  // Sign and zero flag delay line
  always_ff @(posedge clk) begin
    if (adv) begin
      neg_d[0]  <= neg_c;
      zero_d[0] <= zero_c;
      for (int i = 1; i < LAT; i++) begin
        neg_d[i]  <= neg_d[i-1];
        zero_d[i] <= zero_d[i-1];
      end
    end
  end

  // One divide/root pipe per component
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_comp
      logic [vn_pkg::ROOT_W:0] half;

      vn_mag_pipe u_mag (
        .clk  (clk),
        .en   (adv),
        .a2   (sq_c[g]),
        .sum  (sum_c),
        .root (root[g])
      );

      // Round: m = (root + 1) / 2, clamped to one
      always_comb begin
        half = (vn_pkg::HALF_W'(root[g]) + 1'b1) >> 1;
        if (half > (vn_pkg::HALF_W'(1) << vn_pkg::FRAC)) begin
          half = vn_pkg::HALF_W'(1) << vn_pkg::FRAC;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          if (zero_d[LAT-1]) begin
            res[g] <= '0;
          end else if (neg_d[LAT-1][g]) begin
            res[g] <= vn_pkg::OUT_W'(~half + 1'b1);
          end else begin
            res[g] <= vn_pkg::OUT_W'(half);
          end
        end
      end
    end
  endgenerate

  // Zero flag output register
  always_ff @(posedge clk) begin
    if (adv) begin
      zero_vector <= zero_d[LAT-1];
    end
  end

  assign unit_x = res[0];
  assign unit_y = res[1];
  assign unit_z = res[2];

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector3_normalize_top. Each accepted vector is run
// through a bit-exact unit vector predictor and queued; every result word is
// checked field by field against the oldest queued unit vector. Random idle
// bursts on both channels, a long output hold and a full drain are applied.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [191:0] wide_t;
  typedef struct packed {
    logic signed [vn_pkg::OUT_W-1:0] ux;
    logic signed [vn_pkg::OUT_W-1:0] uy;
    logic signed [vn_pkg::OUT_W-1:0] uz;
    logic                            zv;
  } unit_vec_t;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 20000;
  localparam logic [vn_pkg::FRAC:0] ONE_MAG = 1 << vn_pkg::FRAC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [vn_pkg::IN_W-1:0] comp_x = '0;
  logic signed [vn_pkg::IN_W-1:0] comp_y = '0;
  logic signed [vn_pkg::IN_W-1:0] comp_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [vn_pkg::OUT_W-1:0] unit_x, unit_y, unit_z;
  logic zero_vector;

  unit_vec_t unit_q[$];
  int errors = 0;
  int idle_cnt = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;

  vector3_normalize_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .zero_vector(zero_vector)
  );

  always #1 clk = ~clk;

  // Largest m in [0, 2^FRAC] with (2m-1)^2 * sum <= a^2 * 4^(FRAC+1)
  function automatic logic [vn_pkg::OUT_W-1:0] rounded_mag(
      logic [vn_pkg::IN_W-1:0] a, wide_t sum);
    wide_t rhs, lhs, d;
    logic [vn_pkg::FRAC:0] m, cand;
    m = '0;
    rhs = (wide_t'(a) * wide_t'(a)) << (2 * vn_pkg::FRAC + 2);
    for (int b = vn_pkg::FRAC; b >= 0; b--) begin
      cand = m | (ONE_MAG >> (vn_pkg::FRAC - b));
      if (cand <= ONE_MAG) begin
        d = 2 * wide_t'(cand) - 1;
        lhs = d * d * sum;
        if (lhs <= rhs) m = cand;
      end
    end
    return vn_pkg::OUT_W'(m);
  endfunction

  function automatic unit_vec_t unit_of(logic [vn_pkg::IN_W-1:0] x,
                                        logic [vn_pkg::IN_W-1:0] y,
                                        logic [vn_pkg::IN_W-1:0] z);
    logic [vn_pkg::IN_W-1:0] mag[3];
    logic [vn_pkg::IN_W-1:0] raw[3];
    logic [vn_pkg::OUT_W-1:0] u[3];
    wide_t sum;
    unit_vec_t r;
    raw[0] = x; raw[1] = y; raw[2] = z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw[i][vn_pkg::IN_W-1] ? -raw[i] : raw[i];
      sum += wide_t'(mag[i]) * wide_t'(mag[i]);
    end
    if (sum == 0) return '{ux: '0, uy: '0, uz: '0, zv: 1'b1};
    for (int i = 0; i < 3; i++) begin
      u[i] = rounded_mag(mag[i], sum);
      if (raw[i][vn_pkg::IN_W-1]) u[i] = -u[i];
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.zv = 1'b0;
    return r;
  endfunction

  // Send one word; returns at the edge where it was accepted
  task automatic send_vec(logic [vn_pkg::IN_W-1:0] x, logic [vn_pkg::IN_W-1:0] y,
                          logic [vn_pkg::IN_W-1:0] z);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    unit_q.push_back(unit_of(x, y, z));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random component: full range, short, shifted, or an edge value
  function automatic logic [vn_pkg::IN_W-1:0] rand_comp();
    logic [vn_pkg::IN_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 15) - 8;
      1: v = $signed(v) >>> $urandom_range(0, 31);
      2: v = v >> $urandom_range(0, 31);
      3: v = '0;
      4: v = {1'b1, {(vn_pkg::IN_W-1){1'b0}}} + $urandom_range(0, 3);
      5: v = {1'b0, {(vn_pkg::IN_W-1){1'b1}}} - $urandom_range(0, 3);
      default: ;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (unit_q.size() != 0) @(posedge clk);
  endtask

  // Zero vector, single axes, extreme magnitudes, ties, mixed signs
  task automatic test_directed();
    logic [vn_pkg::IN_W-1:0] mn, mx;
    mn = {1'b1, {(vn_pkg::IN_W-1){1'b0}}};
    mx = {1'b0, {(vn_pkg::IN_W-1){1'b1}}};
    send_vec(0, 0, 0);
    send_vec(1, 0, 0);
    send_vec(0, -1, 0);
    send_vec(0, 0, mn);
    send_vec(mx, 0, 0);
    send_vec(0, mx, 0);
    send_vec(mn, mn, mn);
    send_vec(mx, mx, mx);
    send_vec(mn, mx, 1);
    send_vec(3, 4, 0);
    send_vec(-3, 0, -4);
    send_vec(1, 1, 1);
    send_vec(-1, -1, -1);
    send_vec(2, -2, 1);
    send_vec(1, 2, 2);
    send_vec(mn, 1, -1);
    send_vec(mx, -1, 0);
    send_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    send_vec(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_vec(12345, -67890, 0);
    send_vec(0, 0, 7);
  endtask

  task automatic test_random(int n);
    repeat (n) send_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  // Receiver holds off while words keep coming; pipe fills, input stalls
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    test_random(150);
    tx_gaps = 1'b1;
  endtask

  // Sender pauses until every result is back
  task automatic test_drain();
    stop_sending();
    wait_drained();
    test_random(60);
  endtask

  task automatic test_no_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random(150);
  endtask

  // Output stall: random bursts, one long hold on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 17)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    unit_vec_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (unit_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: %h %h %h %b", $time,
                 unit_x, unit_y, unit_z, zero_vector);
      end else begin
        exp_v = unit_q.pop_front();
        if (unit_x !== exp_v.ux) begin
          errors++;
          $display("%0t: unit_x expected %0d actual %0d", $time, exp_v.ux, unit_x);
        end
        if (unit_y !== exp_v.uy) begin
          errors++;
          $display("%0t: unit_y expected %0d actual %0d", $time, exp_v.uy, unit_y);
        end
        if (unit_z !== exp_v.uz) begin
          errors++;
          $display("%0t: unit_z expected %0d actual %0d", $time, exp_v.uz, unit_z);
        end
        if (zero_vector !== exp_v.zv) begin
          errors++;
          $display("%0t: zero_vector expected %b actual %b", $time, exp_v.zv,
                   zero_vector);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(320);
    test_backpressure();
    test_drain();
    test_no_idle();
    stop_sending();
    wait_drained();
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
